// ===== rtl/cfe_pkg.sv =====
// shared types and constants for the cobs frame encoder
// no dependencies; imported by every module of the block
`default_nettype none

package cfe_pkg;

    localparam int MAX_BLOCK_DATA = 254;
    localparam int OUT_LANES      = 8;
    localparam int BYTE_W         = 8;
    localparam int LANE_W         = $clog2(OUT_LANES);
    localparam int ROW_W          = OUT_LANES * BYTE_W;
    localparam int ROWS_PER_BANK  = (MAX_BLOCK_DATA + OUT_LANES - 1) / OUT_LANES;
    localparam int ROW_IDX_W      = $clog2(ROWS_PER_BANK);
    localparam int MEM_ADDR_W     = ROW_IDX_W + 1;
    localparam int MEM_DEPTH      = 2 * ROWS_PER_BANK;
    localparam int HELD_W         = 8;
    localparam int COUNT_W        = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int Q_PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W        = Q_PTR_W + 1;

    localparam logic [HELD_W-1:0] FULL_BLOCK = HELD_W'(MAX_BLOCK_DATA);

    typedef struct packed {
        logic             frame_last;
        logic [7:0]       data_byte;
    } item_t;

    typedef struct packed {
        logic [63:0]      out_bytes;
        logic [3:0]       out_count;
        logic             run_last;
        logic             frame_done;
    } result_t;

    // one block close, handed from the front to the back
    typedef struct packed {
        logic              bank;
        logic [HELD_W-1:0] count;
        logic              run_last;
        logic              frame_done;
    } cmd_t;

    // byte write into the block buffer
    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] row;
        logic [LANE_W-1:0]     lane;
        logic [BYTE_W-1:0]     data;
    } wr_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] level;
        logic               empty;
    } q_status_t;

    // back hands a drained bank back to the front
    typedef struct packed {
        logic done;
        logic bank;
    } bank_rel_t;

endpackage

`default_nettype wire

// ===== rtl/cfe_front.sv =====
// front end: accepts raw bytes, fills the block buffer, issues block closes
// depends on cfe_pkg
`default_nettype none

module cfe_front
    import cfe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire item_t     item,
    input  wire q_status_t q_status,
    input  wire bank_rel_t rel,
    output logic           cmd_push,
    output cmd_t           cmd,
    output wr_t            wr
);

    logic [HELD_W-1:0] held_reg, held_next;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic              pend_reg, pend_next;

    logic              accept;
    logic              is_zero;
    logic [HELD_W-1:0] held_inc;
    logic              close1;
    logic              closing;
    logic [HELD_W-1:0] first_count;

    assign full = pend_reg || (q_status.level > Q_CNT_W'(QUEUE_DEPTH - 2))
                  || busy_reg[bank_reg];

    assign accept      = push && !full;
    assign is_zero     = item.data_byte == 8'h00;
    assign held_inc    = held_reg + HELD_W'(1);
    assign close1      = is_zero || (held_inc == FULL_BLOCK);
    assign closing     = close1 || item.frame_last;
    assign first_count = is_zero ? held_reg : held_inc;

    always_comb
    begin
        cmd_push = 1'b0;
        cmd      = '0;
        if (pend_reg)
        begin
            // trailing empty block at frame end
            cmd_push       = 1'b1;
            cmd.bank       = bank_reg;
            cmd.count      = '0;
            cmd.run_last   = 1'b1;
            cmd.frame_done = 1'b1;
        end
        else if (accept && closing)
        begin
            cmd_push       = 1'b1;
            cmd.bank       = bank_reg;
            cmd.count      = first_count;
            cmd.run_last   = !(close1 && item.frame_last);
            cmd.frame_done = item.frame_last && !close1;
        end
    end

    assign wr.en   = accept && !is_zero;
    assign wr.row  = {bank_reg, held_reg[LANE_W +: ROW_IDX_W]};
    assign wr.lane = held_reg[LANE_W-1:0];
    assign wr.data = item.data_byte;

    always_comb
    begin
        held_next = held_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        pend_next = 1'b0;
        if (rel.done)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            held_next = closing ? '0 : held_inc;
            pend_next = close1 && item.frame_last;
            if (closing && first_count != '0)
            begin
                busy_next[bank_reg] = 1'b1;
                bank_next           = !bank_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfe_cmd_queue.sv =====
// short command queue between the front and the back
// depends on cfe_pkg
`default_nettype none

module cfe_cmd_queue
    import cfe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire cmd_t  wr_cmd,
    input  wire logic  rd_en,
    output cmd_t       rd_cmd,
    output q_status_t  status
);

    cmd_t               entries_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] level_reg;

    assign rd_cmd       = entries_reg[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.empty = level_reg == '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   level_reg <= level_reg + Q_CNT_W'(1);
                2'b01:   level_reg <= level_reg - Q_CNT_W'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfe_back.sv =====
// back end: block buffer memory, reads closed blocks row by row, packs results
// depends on cfe_pkg
`default_nettype none

module cfe_back
    import cfe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire wr_t       wr,
    input  wire logic      q_empty,
    input  wire cmd_t      q_cmd,
    output logic           q_pop,
    output bank_rel_t      rel,
    input  wire logic      pop,
    output logic           empty,
    output result_t        result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    logic [ROW_W-1:0]     mem [MEM_DEPTH];
    logic [ROW_W-1:0]     rd_data_reg;

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [ROW_IDX_W-1:0] word_reg;
    logic [BYTE_W-1:0]    prev_hi_reg;
    result_t              out_reg;
    logic                 out_valid_reg;

    logic [HELD_W:0]      words_sum;
    logic [HELD_W:0]      words_m1;
    logic [ROW_IDX_W-1:0] last_idx;
    logic                 is_last_word;
    logic [COUNT_W-1:0]   lanes;
    logic [BYTE_W-1:0]    code;
    logic [BYTE_W-1:0]    low_byte;
    logic [ROW_W-1:0]     raw_word;
    logic [ROW_W-1:0]     packed_word;
    logic                 slot_free;
    logic                 load;

    // byte-lane writes from the front
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row][BYTE_W * wr.lane +: BYTE_W] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem[{cmd_reg.bank, word_reg}];
        end
    end

    assign words_sum    = {1'b0, cmd_reg.count} + (HELD_W+1)'(OUT_LANES);
    assign words_m1     = (words_sum >> LANE_W) - (HELD_W+1)'(1);
    assign last_idx     = words_m1[ROW_IDX_W-1:0];
    assign is_last_word = word_reg == last_idx;
    assign lanes        = is_last_word
                          ? COUNT_W'(cmd_reg.count[LANE_W-1:0]) + COUNT_W'(1)
                          : COUNT_W'(OUT_LANES);
    assign code         = cmd_reg.count + HELD_W'(1);

    // lane 0 carries the code byte, or the top byte of the previous row
    assign low_byte = (word_reg == '0) ? code : prev_hi_reg;
    assign raw_word = {rd_data_reg[ROW_W-BYTE_W-1:0], low_byte};

    always_comb
    begin
        for (int l = 0; l < OUT_LANES; l++)
        begin
            packed_word[l*BYTE_W +: BYTE_W] = (COUNT_W'(l) < lanes)
                                              ? raw_word[l*BYTE_W +: BYTE_W]
                                              : '0;
        end
    end

    assign slot_free = !out_valid_reg || pop;
    assign load      = (state_reg == ST_EMIT) && slot_free;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign rel.done  = (state_reg == ST_EMIT) && slot_free && is_last_word
                       && (cmd_reg.count != '0);
    assign rel.bank  = cmd_reg.bank;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            word_reg      <= '0;
            prev_hi_reg   <= '0;
            out_reg       <= '0;
        end
        else
        begin
            // a new word refills the slot in the same cycle the old one leaves
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg   <= q_cmd;
                        word_reg  <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_reg.out_bytes  <= packed_word;
                        out_reg.out_count  <= lanes;
                        out_reg.run_last   <= is_last_word && cmd_reg.run_last;
                        out_reg.frame_done <= is_last_word && cmd_reg.frame_done;
                        prev_hi_reg        <= rd_data_reg[ROW_W-1 -: BYTE_W];
                        if (is_last_word)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            word_reg  <= word_reg + ROW_IDX_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cobs_frame_encoder_top.sv =====
// top level of the cobs frame encoder: front end, command queue, back end
// depends on cfe_pkg, cfe_front, cfe_cmd_queue, cfe_back
//
// usage
// - input channel: a raw frame byte with its frame_last flag is a transfer
//   when push is high and full is low
// - result channel: the oldest packed result sits on result while empty is
//   low; it is a transfer when pop is high and empty is low
// - each closed block (code byte then held bytes) is packed from a fresh
//   result, up to eight bytes per result, first byte in the low lane
// - input rate: one byte per cycle while a block fills and full is low;
//   a byte closing two blocks at frame end raises full for the empty block
// - the back end drains a block of n held bytes as ceil((n+1)/8) output
//   words: one buffer row read and one result load per output word
// - a close passes the command queue, then the back end's read and emit states
// - the block buffer has two banks; full rises while the bank being filled
//   is still draining, the command queue is nearly full or a trailing block is due
// - a stalled receiver holds the result register and the back end; the
//   front keeps taking bytes until both banks are in use or the queue is nearly full
// - reset clears the held count, bank ownership, the queue and the result
//   register; the buffer contents are not cleared
`default_nettype none

module cobs_frame_encoder_top
    import cfe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire item_t   item,
    input  wire logic    pop,
    output logic         empty,
    output result_t      result
);

    // front to queue
    logic      cmd_push;
    cmd_t      cmd_in;

    // queue to back
    cmd_t      cmd_out;
    logic      cmd_pop;
    q_status_t q_status;

    // buffer writes and bank hand-back
    wr_t       wr;
    bank_rel_t rel;

    cfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .q_status (q_status),
        .rel      (rel),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .wr       (wr)
    );

    cfe_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd_in),
        .rd_en  (cmd_pop),
        .rd_cmd (cmd_out),
        .status (q_status)
    );

    cfe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .q_empty (q_status.empty),
        .q_cmd   (cmd_out),
        .q_pop   (cmd_pop),
        .rel     (rel),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // a waiting result always carries one to eight lanes
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.out_count != '0 && result.out_count <= COUNT_W'(OUT_LANES)))
        else $error("result lane count out of range");

    // the frame's final byte is always on the last result of its input
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_done) |-> result.run_last)
        else $error("frame_done without run_last");

    // front never pushes a close into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (q_status.level != Q_CNT_W'(QUEUE_DEPTH)))
        else $error("command queue overflow");

    // a waiting result holds still until it is popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before pop");

endmodule

`default_nettype wire
